// ===== rtl/skte_pkg.sv =====
// ----------------------------------------------------------------------------
// skte_pkg - shared types and codes for the sorted key table engine
// Opcodes, status codes, field widths and the cell-to-cell entry and command
// structures.
// ----------------------------------------------------------------------------
package skte_pkg;

	localparam int KEY_W    = 10;
	localparam int VAL_W    = 16;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 6;

	localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND_KEY = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND_VAL = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// broadcast to every cell: update strobes plus the item's key and value
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== rtl/skte_cell.sv =====
// ----------------------------------------------------------------------------
// skte_cell - one position of the sorted table
// Holds a key/value pair, compares it with the broadcast key and value, and on
// an insert or delete takes the entry of its lower or upper neighbor.
// ----------------------------------------------------------------------------
module skte_cell (
	input  logic                clk,
	input  skte_pkg::cell_cmd_t cmd,
	input  logic                valid,       // position below occupancy
	input  logic                prev_valid,  // tied high for position 0
	input  logic                prev_gt,     // tied low for position 0
	input  skte_pkg::entry_t    prev_ent,
	input  skte_pkg::entry_t    next_ent,
	output skte_pkg::entry_t    ent,
	output logic                gt,
	output logic                key_eq,
	output logic                val_eq
);
	import skte_pkg::*;

	entry_t ent_q;
	logic   ins_wr;
	logic   del_wr;

	assign ent    = ent_q;
	assign gt     = valid && (ent_q.key > cmd.key);
	assign key_eq = valid && (ent_q.key == cmd.key);
	assign val_eq = valid && (ent_q.value == cmd.value);

	// insert: larger keys move up one, the first free or first larger slot
	// takes the new entry
	assign ins_wr = cmd.ins && (gt || (!valid && prev_valid));
	// delete: the key is present, so every entry at or above it moves down
	assign del_wr = cmd.del && (gt || key_eq);

	always_ff @(posedge clk) begin
		if (ins_wr) begin
			if (prev_gt) begin
				ent_q <= prev_ent;
			end else begin
				ent_q <= '{key: cmd.key, value: cmd.value};
			end
		end else if (del_wr) begin
			ent_q <= next_ent;
		end
	end

endmodule

// ===== rtl/sorted_key_table_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_engine - sorted key/value table built as a row of cells
// Insert, delete and search over a table kept in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item: opcode, entry_key, entry_value.
//   m_axis returns result items: status, match_index, entry_count, with
//   tlast set on the final result of a command.
//   Insert and delete give one result; a search gives one result per matching
//   position in ascending order, or a single not-found result.
// Timing:
//   The command is registered when accepted, compared across all cells
//   (S_CMP), then the table is updated and the first result registered
//   (S_RESP). A search then walks the match vector one position per cycle,
//   stopping at a matching position while the output register is held.
//   One command is in progress at a time; the next is accepted once the
//   current one has handed its last result to the output register.
// Reset:
//   arst_n empties the table (occupancy zero); stored entries are not cleared.
// Stall:
//   A held output register stops the engine at its next result until m_axis_tready; the table
//   is updated only when its result is loaded.
// ----------------------------------------------------------------------------
module sorted_key_table_engine #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // opcode[1:0], entry_key[11:2], entry_value[27:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status[2:0], match_index[7:3], entry_count[13:8]
	output logic        m_axis_tlast
);
	import skte_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [CW-1:0]       occ_q;
	logic [CAPACITY-1:0] hits_q;
	logic                any_q;
	logic [IW-1:0]       idx_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_last_q;

	cell_cmd_t           cmd;
	entry_t              ent_w      [CAPACITY];
	entry_t              prev_ent_w [CAPACITY];
	entry_t              next_ent_w [CAPACITY];
	logic [CAPACITY-1:0] vld_w;
	logic [CAPACITY-1:0] prev_vld_w;
	logic [CAPACITY-1:0] prev_gt_w;
	logic [CAPACITY-1:0] gt_w;
	logic [CAPACITY-1:0] key_eq_w;
	logic [CAPACITY-1:0] val_eq_w;
	logic [CAPACITY-1:0] hit_sel;

	logic can_load;
	logic full;
	logic apply_ins;
	logic apply_del;
	logic rest_empty;
	logic res_load;

	assign can_load   = !out_valid_q || m_axis_tready;
	assign full       = (occ_q == CW'(CAPACITY));
	assign apply_ins  = (state_q == S_RESP) && (op_q == OP_INSERT) && can_load
		&& !any_q && !full;
	assign apply_del  = (state_q == S_RESP) && (op_q == OP_DELETE) && can_load && any_q;
	assign hit_sel    = (op_q == OP_FIND_VAL) ? val_eq_w : key_eq_w;
	assign rest_empty = ((hits_q >> 1) == '0);
	// a result item enters the output register this cycle
	assign res_load   = (state_q == S_RESP) && can_load
		&& (op_q == OP_INSERT || op_q == OP_DELETE || !any_q || hits_q[0]);

	assign cmd = '{ins: apply_ins, del: apply_del, key: key_q, value: value_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign vld_w[i] = (occ_q > CW'(i));
		if (i == 0) begin : g_first
			assign prev_vld_w[i] = 1'b1;
			assign prev_gt_w[i]  = 1'b0;
			assign prev_ent_w[i] = '0;
		end else begin : g_mid
			assign prev_vld_w[i] = vld_w[i-1];
			assign prev_gt_w[i]  = gt_w[i-1];
			assign prev_ent_w[i] = ent_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_ent_w[i] = '0;
		end else begin : g_inner
			assign next_ent_w[i] = ent_w[i+1];
		end

		skte_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (vld_w[i]),
			.prev_valid (prev_vld_w[i]),
			.prev_gt    (prev_gt_w[i]),
			.prev_ent   (prev_ent_w[i]),
			.next_ent   (next_ent_w[i]),
			.ent        (ent_w[i]),
			.gt         (gt_w[i]),
			.key_eq     (key_eq_w[i]),
			.val_eq     (val_eq_w[i])
		);
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_count_q, out_index_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tdata[1:0];
						key_q   <= s_axis_tdata[11:2];
						value_q <= s_axis_tdata[27:12];
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					hits_q  <= hit_sel;
					any_q   <= |hit_sel;
					idx_q   <= '0;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (op_q == OP_INSERT || op_q == OP_DELETE) begin
						if (can_load) begin
							out_index_q <= '0;
							out_last_q  <= 1'b1;
							state_q     <= S_IDLE;
							if (op_q == OP_INSERT) begin
								if (any_q) begin
									out_status_q <= ST_DUP;
									out_count_q  <= COUNT_W'(occ_q);
								end else if (full) begin
									out_status_q <= ST_FULL;
									out_count_q  <= COUNT_W'(occ_q);
								end else begin
									out_status_q <= ST_DONE;
									out_count_q  <= COUNT_W'(occ_q + CW'(1));
									occ_q        <= occ_q + CW'(1);
								end
							end else if (any_q) begin
								out_status_q <= ST_DONE;
								out_count_q  <= COUNT_W'(occ_q - CW'(1));
								occ_q        <= occ_q - CW'(1);
							end else begin
								out_status_q <= ST_NOTFOUND;
								out_count_q  <= COUNT_W'(occ_q);
							end
						end
					end else if (!any_q) begin
						if (can_load) begin
							out_status_q <= ST_NOTFOUND;
							out_index_q  <= '0;
							out_count_q  <= COUNT_W'(occ_q);
							out_last_q   <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else if (hits_q[0]) begin
						if (can_load) begin
							out_status_q <= ST_MATCH;
							out_index_q  <= INDEX_W'(idx_q);
							out_count_q  <= COUNT_W'(occ_q);
							out_last_q   <= rest_empty;
							hits_q       <= hits_q >> 1;
							idx_q        <= idx_q + IW'(1);
							if (rest_empty) begin
								state_q <= S_IDLE;
							end
						end
					end else begin
						// skip a position without a match
						hits_q <= hits_q >> 1;
						idx_q  <= idx_q + IW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/skte_result_checker.sv =====
// ----------------------------------------------------------------------------
// skte_result_checker - result predictor and checker for the key table engine
// Watches both stream channels. Every accepted command item is run against a
// private sorted key/value table and the result items it causes are queued.
// Every accepted result item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module skte_result_checker #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // opcode[1:0], entry_key[11:2], entry_value[27:12]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // status[2:0], match_index[7:3], entry_count[13:8]
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          open_results
);

	import skte_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} table_result_t;

	table_result_t    due_results[$];
	table_result_t    oldest;
	logic [KEY_W-1:0] keys_held[CAPACITY];
	logic [VAL_W-1:0] values_held[CAPACITY];
	int               held;
	int               errors = 0;

	assign mismatches = errors;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// count field carries the occupancy after the command has been applied
	task automatic queue_result(input logic [STATUS_W-1:0] status, input int index,
		input logic last);
		table_result_t r;
		r.status = status;
		r.index  = INDEX_W'(index);
		r.count  = COUNT_W'(held);
		r.last   = last;
		due_results.push_back(r);
	endtask

	function automatic int key_position(input logic [KEY_W-1:0] key);
		for (int i = 0; i < held; i++) begin
			if (keys_held[i] == key) begin
				return i;
			end
		end
		return held;
	endfunction

	task automatic apply_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		int pos;
		int hits[$];
		case (op)
		OP_INSERT: begin
			pos = key_position(key);
			// duplicate wins over full
			if (pos < held) begin
				queue_result(ST_DUP, 0, 1'b1);
			end else if (held >= CAPACITY) begin
				queue_result(ST_FULL, 0, 1'b1);
			end else begin
				pos = held;
				while (pos > 0 && keys_held[pos-1] > key) begin
					keys_held[pos]   = keys_held[pos-1];
					values_held[pos] = values_held[pos-1];
					pos--;
				end
				keys_held[pos]   = key;
				values_held[pos] = value;
				held++;
				queue_result(ST_DONE, 0, 1'b1);
			end
		end
		OP_DELETE: begin
			pos = key_position(key);
			if (pos >= held) begin
				queue_result(ST_NOTFOUND, 0, 1'b1);
			end else begin
				for (int i = pos; i + 1 < held; i++) begin
					keys_held[i]   = keys_held[i+1];
					values_held[i] = values_held[i+1];
				end
				held--;
				queue_result(ST_DONE, 0, 1'b1);
			end
		end
		default: begin
			for (int i = 0; i < held; i++) begin
				if (op == OP_FIND_KEY ? keys_held[i] == key : values_held[i] == value) begin
					hits.push_back(i);
				end
			end
			if (hits.size() == 0) begin
				queue_result(ST_NOTFOUND, 0, 1'b1);
			end else begin
				foreach (hits[j]) begin
					queue_result(ST_MATCH, hits[j], j == hits.size() - 1);
				end
			end
		end
		endcase
	endtask

	// results are taken before commands: a command never answers in its own cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			due_results.delete();
			open_results <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result item with none expected, tdata", m_axis_tdata, 0);
				end else begin
					oldest = due_results.pop_front();
					if (m_axis_tdata[2:0] != oldest.status) begin
						report_mismatch("status", m_axis_tdata[2:0], oldest.status);
					end
					if (m_axis_tdata[7:3] != oldest.index) begin
						report_mismatch("match_index", m_axis_tdata[7:3], oldest.index);
					end
					if (m_axis_tdata[13:8] != oldest.count) begin
						report_mismatch("entry_count", m_axis_tdata[13:8], oldest.count);
					end
					if (m_axis_tlast !== oldest.last) begin
						report_mismatch("tlast", m_axis_tlast, oldest.last);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_command(s_axis_tdata[1:0], s_axis_tdata[11:2], s_axis_tdata[27:12]);
			end
			open_results <= due_results.size();
		end
	end

endmodule

// ===== bench/tb_sorted_key_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_key_table_engine - testbench for the sorted key table engine
// Directed commands on an empty and a nearly empty table, a fill to capacity
// under a long output stall, then random insert/delete/search traffic over a
// small key pool so that hits, misses, full and duplicate cases keep coming.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_engine;

	import skte_pkg::*;

	localparam int CAPACITY     = 32;
	localparam int RANDOM_ITEMS = 290;
	localparam int QUIET_ITEMS  = 40;
	localparam int LONG_HOLD    = 400;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // opcode[1:0], entry_key[11:2], entry_value[27:12]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // status[2:0], match_index[7:3], entry_count[13:8]
	logic        m_axis_tlast;

	int mismatches;
	int open_results;
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;

	logic [KEY_W-1:0] key_pool[40];
	logic [VAL_W-1:0] value_pool[6];

	sorted_key_table_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	skte_result_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.open_results  (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// offer one command item, with an occasional idle burst ahead of it
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, value, key, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop valid and wait until the checker has seen every queued result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (open_results != 0);
	endtask

	// result side
	initial begin : result_sink
		bit hold_served;
		hold_served = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : command_source
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		int               r;
		bit               insert_phase;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;

		// pool keys 0..31 match the fill keys, the rest are arbitrary
		for (int i = 0; i < 40; i++) begin
			key_pool[i] = (i < 32) ? KEY_W'(i * 33) : KEY_W'($urandom_range(0, 1023));
		end
		value_pool[0] = 16'h0000;
		value_pool[1] = 16'hFFFF;
		value_pool[2] = 16'h5A5A;
		for (int i = 3; i < 6; i++) begin
			value_pool[i] = VAL_W'($urandom_range(0, 65535));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty table
		send_cmd(OP_FIND_KEY, 10'd0, 16'd0);
		send_cmd(OP_FIND_VAL, 10'd0, 16'd0);
		send_cmd(OP_DELETE, 10'd0, 16'd0);
		// out-of-order inserts, middle insert shifts the top entry
		send_cmd(OP_INSERT, 10'd1023, 16'hFFFF);
		send_cmd(OP_INSERT, 10'd0, 16'h0000);
		send_cmd(OP_INSERT, 10'd500, 16'h0000);
		send_cmd(OP_INSERT, 10'd1023, 16'h0001);
		send_cmd(OP_FIND_KEY, 10'd1023, 16'h0000);
		send_cmd(OP_FIND_KEY, 10'd7, 16'h0000);
		send_cmd(OP_FIND_VAL, 10'd0, 16'h0000);
		send_cmd(OP_FIND_VAL, 10'd0, 16'hFFFF);
		send_cmd(OP_FIND_VAL, 10'd0, 16'd1234);
		send_cmd(OP_DELETE, 10'd500, 16'h0000);
		send_cmd(OP_DELETE, 10'd500, 16'h0000);
		// key below the top entry, which moves up
		send_cmd(OP_INSERT, 10'd1000, 16'hFFFF);
		send_cmd(OP_FIND_VAL, 10'd0, 16'hFFFF);
		send_cmd(OP_DELETE, 10'd0, 16'h0000);
		send_cmd(OP_DELETE, 10'd1023, 16'h0000);
		send_cmd(OP_DELETE, 10'd1000, 16'h0000);
		send_cmd(OP_FIND_KEY, 10'd1023, 16'h0000);

		// fill to capacity in descending key order while the sink holds off
		hold_req = 1'b1;
		for (int k = 0; k < CAPACITY; k++) begin
			send_cmd(OP_INSERT, KEY_W'((31 - k) * 33), 16'h5A5A);
		end
		send_cmd(OP_INSERT, 10'd7, 16'h1111);
		send_cmd(OP_INSERT, 10'd1023, 16'h0000);
		send_cmd(OP_FIND_VAL, 10'd0, 16'h5A5A);
		send_cmd(OP_FIND_KEY, 10'd0, 16'h0000);
		send_cmd(OP_FIND_KEY, 10'd1023, 16'h0000);
		drain_results();

		// table starts full, so the first phase leans toward deletes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet        = (n >= RANDOM_ITEMS - QUIET_ITEMS);
			insert_phase = ((n / 50) % 2) == 1;
			r            = $urandom_range(0, 99);
			if (r < 8) begin
				op    = OP_W'($urandom_range(0, 3));
				key   = KEY_W'($urandom_range(0, 1023));
				value = VAL_W'($urandom_range(0, 65535));
			end else begin
				key   = key_pool[$urandom_range(0, 39)];
				value = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 65535))
					: value_pool[$urandom_range(0, 5)];
				if (r < 53) begin
					op = insert_phase ? OP_INSERT : OP_DELETE;
				end else if (r < 68) begin
					op = insert_phase ? OP_DELETE : OP_INSERT;
				end else if (r < 84) begin
					op = OP_FIND_KEY;
				end else begin
					op = OP_FIND_VAL;
				end
			end
			send_cmd(op, key, value);
		end

		drain_results();
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatches == 0 && open_results == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
